@@ src/imubc_pkg.sv @@
`timescale 1ns / 1ps

package imubc_pkg;

  localparam int AxisN        = 6;
  localparam int AccelZ       = 2;
  localparam int CntW         = 16;
  localparam int SumW         = 23;
  localparam int DiffW        = 24;
  localparam int ScaleW       = 20;
  localparam int ProdW        = DiffW + ScaleW;
  localparam int FracW        = 24;
  localparam int ShW          = ProdW - FracW;
  localparam int GravW        = 18;
  localparam int ZSumW        = ShW + 1;
  localparam int OutW         = 19;
  localparam int SecW         = 32;
  localparam int NsecW        = 30;
  localparam int CfgIdxW      = 2;
  localparam int CfgDataW     = 20;
  localparam int CalibSamples = 100;
  localparam int CntrW        = 7;

  localparam logic [ScaleW-1:0] AccelScaleRst = ScaleW'(411055);
  localparam logic [ScaleW-1:0] GyroScaleRst  = ScaleW'(327692);
  localparam logic [GravW-1:0]  GravityRst    = GravW'(10015);
  localparam logic [CntrW-1:0]  CalibInit     = CntrW'(CalibSamples);
  localparam logic signed [SumW-1:0] CalibMul = SumW'(CalibSamples);

  localparam logic signed [ZSumW-1:0] OutMax = ZSumW'((1 << (OutW - 1)) - 1);
  localparam logic signed [ZSumW-1:0] OutMin = -ZSumW'(1 << (OutW - 1));

  typedef logic signed [CntW-1:0]   cnt_t;
  typedef logic signed [SumW-1:0]   sum_t;
  typedef logic signed [DiffW-1:0]  diff_t;
  typedef logic        [ScaleW-1:0] scale_t;
  typedef logic signed [ProdW-1:0]  prod_t;
  typedef logic signed [GravW-1:0]  grav_t;
  typedef logic signed [OutW-1:0]   res_t;

  typedef enum logic [CfgIdxW-1:0] {
    CfgAccelScale = 2'd0,
    CfgGyroScale  = 2'd1,
    CfgGravity    = 2'd2
  } cfg_reg_e;

  typedef struct packed {
    logic cal_add;
    logic s1_en;
    logic s2_en;
  } lane_ctrl_t;

  function automatic res_t sat_res(input logic signed [ZSumW-1:0] v);
    res_t r;
    if (v > OutMax) begin
      r = OutMax[OutW-1:0];
    end else if (v < OutMin) begin
      r = OutMin[OutW-1:0];
    end else begin
      r = v[OutW-1:0];
    end
    return r;
  endfunction

endpackage

@@ src/imubc_lane.sv @@
`timescale 1ns / 1ps

module imubc_lane (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  imubc_pkg::lane_ctrl_t  ctrl_i,
  input  imubc_pkg::cnt_t        cnt_i,
  input  imubc_pkg::scale_t      scale_i,
  output imubc_pkg::prod_t       prod_o
);
  import imubc_pkg::*;

  sum_t  sum_q, sum_d;
  sum_t  cnt_ext;
  sum_t  cnt_x;
  diff_t diff_q, diff_d;
  prod_t prod_q, prod_d;
  logic signed [ScaleW:0] scale_s;

  assign cnt_ext = SumW'(cnt_i);
  assign cnt_x   = cnt_ext * CalibMul;
  assign sum_d   = sum_q + cnt_ext;
  assign diff_d  = DiffW'(cnt_x) - DiffW'(sum_q);
  assign scale_s = $signed({1'b0, scale_i});
  assign prod_d  = ProdW'(diff_q) * ProdW'(scale_s);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q <= '0;
    end else if (ctrl_i.cal_add) begin
      sum_q <= sum_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.s1_en) begin
      diff_q <= diff_d;
    end
    if (ctrl_i.s2_en) begin
      prod_q <= prod_d;
    end
  end

  assign prod_o = prod_q;

endmodule

@@ src/imubc_merge.sv @@
`timescale 1ns / 1ps

module imubc_merge (
  input  logic                                clk_i,
  input  logic                                load_i,
  input  imubc_pkg::prod_t                    prod_i [imubc_pkg::AxisN],
  input  imubc_pkg::grav_t                    gravity_i,
  input  logic [imubc_pkg::SecW-1:0]          sec_i,
  input  logic [imubc_pkg::NsecW-1:0]         nsec_i,
  output imubc_pkg::res_t                     res_o [imubc_pkg::AxisN],
  output logic [imubc_pkg::SecW-1:0]          sec_o,
  output logic [imubc_pkg::NsecW-1:0]         nsec_o
);
  import imubc_pkg::*;

  res_t res_q [AxisN];
  res_t res_d [AxisN];
  logic [SecW-1:0]  sec_q;
  logic [NsecW-1:0] nsec_q;

  always_comb begin
    logic signed [ShW-1:0]   sh;
    logic signed [ZSumW-1:0] acc;
    for (int i = 0; i < AxisN; i++) begin
      sh  = prod_i[i][ProdW-1:FracW];
      acc = ZSumW'(sh);
      if (i == AccelZ) begin
        acc = acc + ZSumW'(gravity_i);
      end
      res_d[i] = sat_res(acc);
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q  <= res_d;
      sec_q  <= sec_i;
      nsec_q <= nsec_i;
    end
  end

  assign res_o  = res_q;
  assign sec_o  = sec_q;
  assign nsec_o = nsec_q;

endmodule

@@ src/imu_bias_calibrate_scale.sv @@
`timescale 1ns / 1ps

// IMU start-up bias calibration with fixed-point scaling.
// Input beats carry one six-axis sample and its time stamp on a valid/ready
// channel; result beats leave on a second valid/ready channel. The first 100
// input beats after reset only build the per-axis bias sums and produce no
// result. Every later input beat produces exactly one result beat.
// Each axis has its own lane that forms the count difference and multiplies
// it by the group scale; a merging stage shifts, adds the gravity offset to
// accel z, saturates and holds the result in the output register.
// A result beat passes through the difference, product and output registers
// before it is valid and leaves when the receiver is ready. Throughput is
// one beat per cycle; the three stages advance independently, so bubbles
// are squeezed out and input ready only drops when all stages hold a
// waiting beat while the receiver stalls. The stall reaches the input
// port in the same cycle. Reset clears the bias sums, reloads the
// calibration count and restores the default scale and gravity
// registers. Register writes take effect at once and are intended only
// while no beat is in flight.
module imu_bias_calibrate_scale (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [imubc_pkg::CfgIdxW-1:0]     cfg_idx_i,
  input  logic [imubc_pkg::CfgDataW-1:0]    cfg_wdata_i,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic signed [imubc_pkg::CntW-1:0] accel_x_i,
  input  logic signed [imubc_pkg::CntW-1:0] accel_y_i,
  input  logic signed [imubc_pkg::CntW-1:0] accel_z_i,
  input  logic signed [imubc_pkg::CntW-1:0] gyro_x_i,
  input  logic signed [imubc_pkg::CntW-1:0] gyro_y_i,
  input  logic signed [imubc_pkg::CntW-1:0] gyro_z_i,
  input  logic [imubc_pkg::SecW-1:0]        stamp_sec_i,
  input  logic [imubc_pkg::NsecW-1:0]       stamp_nsec_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic signed [imubc_pkg::OutW-1:0] acc_x_out_o,
  output logic signed [imubc_pkg::OutW-1:0] acc_y_out_o,
  output logic signed [imubc_pkg::OutW-1:0] acc_z_out_o,
  output logic signed [imubc_pkg::OutW-1:0] rate_x_out_o,
  output logic signed [imubc_pkg::OutW-1:0] rate_y_out_o,
  output logic signed [imubc_pkg::OutW-1:0] rate_z_out_o,
  output logic [imubc_pkg::SecW-1:0]        out_sec_o,
  output logic [imubc_pkg::NsecW-1:0]       out_nsec_o
);
  import imubc_pkg::*;

  scale_t accel_scale_q;
  scale_t gyro_scale_q;
  grav_t  gravity_q;

  logic [CntrW-1:0] left_q, left_d;
  logic v1_q, v2_q, v3_q;
  logic en1, en2, en3;
  logic accept, calib;

  logic [SecW-1:0]  sec1_q, sec2_q;
  logic [NsecW-1:0] nsec1_q, nsec2_q;

  cnt_t       cnt [AxisN];
  prod_t      prod [AxisN];
  res_t       res [AxisN];
  lane_ctrl_t lane_ctrl;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      accel_scale_q <= AccelScaleRst;
      gyro_scale_q  <= GyroScaleRst;
      gravity_q     <= GravityRst;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        CfgAccelScale: accel_scale_q <= cfg_wdata_i[ScaleW-1:0];
        CfgGyroScale:  gyro_scale_q  <= cfg_wdata_i[ScaleW-1:0];
        CfgGravity:    gravity_q     <= cfg_wdata_i[GravW-1:0];
        default: ;
      endcase
    end
  end

  assign en3        = !v3_q || out_ready_i;
  assign en2        = !v2_q || en3;
  assign en1        = !v1_q || en2;
  assign in_ready_o = en1;
  assign accept     = in_valid_i && en1;
  assign calib      = (left_q != '0);
  assign left_d     = left_q - CntrW'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_q <= CalibInit;
      v1_q   <= 1'b0;
      v2_q   <= 1'b0;
      v3_q   <= 1'b0;
    end else begin
      if (accept && calib) begin
        left_q <= left_d;
      end
      if (en1) begin
        v1_q <= accept && !calib;
      end
      if (en2) begin
        v2_q <= v1_q;
      end
      if (en3) begin
        v3_q <= v2_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en1) begin
      sec1_q  <= stamp_sec_i;
      nsec1_q <= stamp_nsec_i;
    end
    if (en2) begin
      sec2_q  <= sec1_q;
      nsec2_q <= nsec1_q;
    end
  end

  assign cnt[0] = accel_x_i;
  assign cnt[1] = accel_y_i;
  assign cnt[2] = accel_z_i;
  assign cnt[3] = gyro_x_i;
  assign cnt[4] = gyro_y_i;
  assign cnt[5] = gyro_z_i;

  assign lane_ctrl.cal_add = accept && calib;
  assign lane_ctrl.s1_en   = en1;
  assign lane_ctrl.s2_en   = en2;

  for (genvar g = 0; g < AxisN; g++) begin : g_lane
    imubc_lane u_lane (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctrl_i  (lane_ctrl),
      .cnt_i   (cnt[g]),
      .scale_i ((g <= AccelZ) ? accel_scale_q : gyro_scale_q),
      .prod_o  (prod[g])
    );
  end

  imubc_merge u_merge (
    .clk_i     (clk_i),
    .load_i    (en3),
    .prod_i    (prod),
    .gravity_i (gravity_q),
    .sec_i     (sec2_q),
    .nsec_i    (nsec2_q),
    .res_o     (res),
    .sec_o     (out_sec_o),
    .nsec_o    (out_nsec_o)
  );

  assign out_valid_o  = v3_q;
  assign acc_x_out_o  = res[0];
  assign acc_y_out_o  = res[1];
  assign acc_z_out_o  = res[2];
  assign rate_x_out_o = res[3];
  assign rate_y_out_o = res[4];
  assign rate_z_out_o = res[5];

  a_calib_no_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && calib) |=> !v1_q)
    else $error("A calibration beat entered the result pipeline.");

  a_valid_after_calib : assert property (@(posedge clk_i) disable iff (!rst_ni)
    v1_q |-> (left_q == '0))
    else $error("A result is in flight before calibration finished.");

  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    left_q <= CalibInit)
    else $error("Calibration count is above its start value.");

  a_ready_free_slot : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !v1_q |-> in_ready_o)
    else $error("Input is stalled while the first stage is empty.");

endmodule
